FILE: rtl/core/zstring_text_decoder_defines.svh
// ----------------------------------------------------------------------------
// zstring_text_decoder_defines
// Assertion macros shared by the text decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ZSTRING_TEXT_DECODER_DEFINES_SVH
`define ZSTRING_TEXT_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ZSTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zstd assertion failed");

// next-cycle implication, disabled in reset
`define ZSTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zstd assertion failed");

`endif

FILE: rtl/core/zstd_pkg.sv
// ----------------------------------------------------------------------------
// zstd_pkg
// Types, codes and character tables of the z-string text decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zstd_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ABBREV = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_DONE   = 2'd3
  } zstd_kind_t;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] ABBREV_LIMIT = 8'd96;

  localparam int NUM_ZCHARS = 3;
  localparam int NUM_SLOTS  = 4;

  typedef struct packed {
    logic [1:0] alpha;
    logic [1:0] bank;
    logic [1:0] esc_rem;
    logic [9:0] esc_code;
  } zstd_state_t;

  typedef struct packed {
    logic       vld;
    zstd_kind_t kind;
    logic [7:0] value;
  } zstd_slot_t;

  typedef struct packed {
    zstd_slot_t [NUM_SLOTS-1:0] slot;
    logic                       eos;
  } zstd_bundle_t;

  function automatic logic [7:0] symbol_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd10:   c = 8'h2E;
      5'd11:   c = 8'h2C;
      5'd12:   c = 8'h21;
      5'd13:   c = 8'h3F;
      5'd14:   c = 8'h5F;
      5'd15:   c = 8'h23;
      5'd16:   c = 8'h27;
      5'd17:   c = 8'h22;
      5'd18:   c = 8'h2F;
      5'd19:   c = 8'h5C;
      5'd20:   c = 8'h2D;
      5'd21:   c = 8'h3A;
      5'd22:   c = 8'h28;
      5'd23:   c = 8'h29;
      default: c = (idx < 5'd10) ? (CH_DIGIT_0 + {3'd0, idx}) : CH_QUESTION;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [1:0] alpha,
                                               input logic [4:0] zc);
    logic [4:0] idx;
    logic [7:0] c;
    idx = zc - 5'd6;
    if (alpha == 2'd0) begin
      c = CH_LOWER_A + {3'd0, idx};
    end else if (alpha == 2'd1) begin
      c = CH_UPPER_A + {3'd0, idx};
    end else if (zc == 5'd7) begin
      c = CH_NEWLINE;
    end else begin
      c = symbol_char(zc - 5'd8);
    end
    return c;
  endfunction

  function automatic logic [7:0] escape_char(input logic [9:0] code);
    logic [7:0] c;
    if (code >= 10'd32 && code <= 10'd126) begin
      c = code[7:0];
    end else if (code == 10'd13) begin
      c = CH_NEWLINE;
    end else if (code == 10'd0) begin
      c = 8'd0;
    end else begin
      c = CH_QUESTION;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/zstd_decode.sv
// ----------------------------------------------------------------------------
// zstd_decode
// Decodes the three z-chars of one text word against the carried state and
// produces the result slots of the word and the state for the next word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zstd_decode
  import zstd_pkg::*;
(
  input  wire  logic [15:0]  text_word,
  input  wire  logic         nested,
  input  wire  zstd_state_t  state_i,
  output zstd_state_t        state_o,
  output zstd_bundle_t       bundle_o
);

  zstd_state_t st;
  logic        stop;
  logic        shifted;
  logic [4:0]  zc;
  logic [7:0]  ch;

  always_comb begin
    st       = state_i;
    stop     = 1'b0;
    shifted  = 1'b0;
    zc       = 5'd0;
    ch       = 8'd0;
    bundle_o = '0;
    for (int i = 0; i < NUM_ZCHARS; i++) begin
      zc      = text_word[14 - 5*i -: 5];
      shifted = 1'b0;
      ch      = 8'd0;
      bundle_o.slot[i].kind = KIND_CHAR;
      if (!stop) begin
        if (st.esc_rem != 2'd0) begin
          if (st.esc_rem == 2'd2) begin
            st.esc_code = st.esc_code | {zc, 5'd0};
          end else begin
            st.esc_code = st.esc_code | {5'd0, zc};
          end
          st.esc_rem = st.esc_rem - 2'd1;
          if (st.esc_rem == 2'd0) begin
            ch          = escape_char(st.esc_code);
            st.alpha    = 2'd0;
            st.bank     = 2'd0;
            st.esc_code = 10'd0;
          end
        end else if (st.bank != 2'd0) begin
          if (nested) begin
            bundle_o.slot[i].vld  = 1'b1;
            bundle_o.slot[i].kind = KIND_ERROR;
            st   = '0;
            stop = 1'b1;
          end else begin
            bundle_o.slot[i].vld   = 1'b1;
            bundle_o.slot[i].kind  = KIND_ABBREV;
            bundle_o.slot[i].value = {1'b0, st.bank - 2'd1, zc};
            st.bank  = 2'd0;
            st.alpha = 2'd0;
          end
        end else begin
          if (zc == 5'd0) begin
            ch = CH_SPACE;
          end else if (zc <= 5'd3) begin
            st.bank = zc[1:0];
          end else if (zc <= 5'd5) begin
            shifted  = 1'b1;
            st.alpha = (zc == 5'd4) ? 2'd1 : 2'd2;
          end else if (zc == 5'd6 && st.alpha == 2'd2) begin
            st.esc_rem = 2'd2;
          end else begin
            ch = alphabet_char(st.alpha, zc);
          end
          if (st.alpha != 2'd0 && !shifted) begin
            st.alpha = 2'd0;
          end
        end
        if (ch != 8'd0) begin
          bundle_o.slot[i].vld   = 1'b1;
          bundle_o.slot[i].kind  = KIND_CHAR;
          bundle_o.slot[i].value = ch;
        end
      end
    end
    bundle_o.slot[NUM_SLOTS-1].vld   = 1'b1;
    bundle_o.slot[NUM_SLOTS-1].kind  = KIND_DONE;
    bundle_o.slot[NUM_SLOTS-1].value = 8'd0;
    bundle_o.eos = text_word[15];
    state_o = text_word[15] ? zstd_state_t'('0) : st;
  end

endmodule

`default_nettype wire

FILE: rtl/core/zstd_out_buf.sv
// ----------------------------------------------------------------------------
// zstd_out_buf
// Result register of one word: holds its slots and hands them out one per
// request, in order, the word-done slot last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zstd_out_buf
  import zstd_pkg::*;
(
  input  wire  logic          clk,
  input  wire  logic          rst_n,
  input  wire  logic          load,
  input  wire  zstd_bundle_t  bundle_i,
  output logic                load_ok,
  output logic                out_valid,
  input  wire  logic          out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_value,
  output logic                out_end_of_string,
  output logic                out_last
);

  localparam int SelW = $clog2(NUM_SLOTS);

  zstd_slot_t [NUM_SLOTS-1:0] slot_r;
  logic                       eos_r;
  logic [NUM_SLOTS-1:0]       pend_r;
  logic [NUM_SLOTS-1:0]       pend_nxt;
  logic [SelW-1:0]            sel;
  logic                       sel_last;

  always_comb begin
    sel = SelW'(NUM_SLOTS - 1);
    for (int i = NUM_SLOTS - 2; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SelW'(i);
      end
    end
  end

  assign sel_last          = (sel == SelW'(NUM_SLOTS - 1));
  assign out_valid         = |pend_r;
  assign out_kind          = slot_r[sel].kind;
  assign out_value         = slot_r[sel].value;
  assign out_last          = sel_last;
  assign out_end_of_string = sel_last & eos_r;
  assign load_ok           = !out_valid || (out_ready && sel_last);

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pend_nxt[i] = bundle_i.slot[i].vld;
      end
    end else if (out_valid && out_ready) begin
      pend_nxt[sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle_i.slot;
      eos_r  <= bundle_i.eos;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/zstring_text_decoder.sv
// ----------------------------------------------------------------------------
// zstring_text_decoder
// Z-machine v3 text word decoder: packed z-char words in, characters,
// abbreviation markers, nesting errors and word-done results out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one 16-bit text word plus the
//   in_abbreviation flag per request. Result channel (out_valid/out_ready)
//   gives one result per request: 0..3 decoded results of the word in order,
//   then a word-done result with out_last high and out_end_of_string = bit 15.
//   A word is registered at input, then decoded combinationally and loaded into
//   the result register once that register can take it: when it is empty or
//   its word-done result is being taken.
//   A word gives 1 to 4 results, one per request on the single result port;
//   the input register accepts the next word while the current one drains,
//   so words follow without gaps.
//   Alphabet shift, pending abbreviation bank and escape code carry from word
//   to word; a word with bit 15 set clears them, as does a nesting error.
//   Reset clears the carried state and empties both registers.
//   When the receiver stalls, the result holds and the input register fills,
//   then in_ready drops until the word-done result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "zstring_text_decoder_defines.svh"

module zstring_text_decoder
  import zstd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_text_word,
  input  wire logic        in_in_abbreviation,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_value,
  output logic             out_end_of_string,
  output logic             out_last
);

  logic         s1_v_r;
  logic [15:0]  s1_word_r;
  logic         s1_nested_r;
  zstd_state_t  state_r;
  zstd_state_t  state_nxt;
  zstd_bundle_t bundle;
  logic         load_ok;
  logic         move;

  assign move     = s1_v_r & load_ok;
  assign in_ready = !s1_v_r || load_ok;

  zstd_decode u_decode (
    .text_word (s1_word_r),
    .nested    (s1_nested_r),
    .state_i   (state_r),
    .state_o   (state_nxt),
    .bundle_o  (bundle)
  );

  zstd_out_buf u_out_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (move),
    .bundle_i          (bundle),
    .load_ok           (load_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_end_of_string (out_end_of_string),
    .out_last          (out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_v_r <= 1'b1;
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r   <= in_text_word;
      s1_nested_r <= in_in_abbreviation;
    end
  end

  `ZSTD_ASSERT_IMP(a_last_is_done, out_valid && out_last, out_kind == KIND_DONE)
  `ZSTD_ASSERT_IMP(a_eos_only_done, out_valid && !out_last, !out_end_of_string)
  `ZSTD_ASSERT_IMP(a_abbrev_range, out_valid && out_kind == KIND_ABBREV, out_value < ABBREV_LIMIT)
  `ZSTD_ASSERT_NXT(a_s1_holds, s1_v_r && !load_ok, s1_v_r && $stable(s1_word_r))
  `ZSTD_ASSERT_NXT(a_eos_clears, move && s1_word_r[15], state_r == '0)

endmodule

`default_nettype wire

FILE: dv/zstd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstd_decode_checker
// Watches both channels of the z-string text decoder. Each accepted word
// request is decoded here into the results it should cause. Every result
// request is compared against the oldest decoded result.
// ----------------------------------------------------------------------------

module zstd_decode_checker
  import zstd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_text_word,
  input  logic        in_in_abbreviation,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_value,
  input  logic        out_end_of_string,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    zstd_kind_t kind;
    logic [7:0] value;
    logic       eos;
    logic       last;
  } zres_t;

  string symbols = "0123456789.,!?_#'\"/\\-:()";

  zres_t      decoded_q[$];
  logic [1:0] cur_alpha;
  logic [1:0] bank_pend;
  logic [1:0] esc_left;
  logic [9:0] esc_acc;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic push_res(input zstd_kind_t k, input logic [7:0] v, input logic e,
                          input logic l);
    zres_t r;
    r.kind  = k;
    r.value = v;
    r.eos   = e;
    r.last  = l;
    decoded_q.push_back(r);
  endtask

  task automatic clear_carry();
    cur_alpha = 2'd0;
    bank_pend = 2'd0;
    esc_left  = 2'd0;
    esc_acc   = 10'd0;
  endtask

  function automatic logic [7:0] glyph(input logic [1:0] alpha, input logic [4:0] zc);
    int idx;
    idx = int'(zc) - 6;
    if (alpha == 2'd0) return 8'(8'h61 + idx);
    if (alpha == 2'd1) return 8'(8'h41 + idx);
    if (zc == 5'd7) return 8'h0A;
    return symbols[int'(zc) - 8];
  endfunction

  function automatic logic [7:0] escape_glyph(input logic [9:0] code);
    if (code >= 10'd32 && code <= 10'd126) return code[7:0];
    if (code == 10'd13) return 8'h0A;
    if (code == 10'd0) return 8'h00;
    return 8'h3F;
  endfunction

  task automatic decode_word(input logic [15:0] w, input logic nested);
    logic [4:0] zc;
    logic [7:0] ch;
    bit         shifted_now;
    bit         stop;
    stop = 1'b0;
    for (int pos = 0; pos < 3; pos++) begin
      if (!stop) begin
        zc = w[14 - 5*pos -: 5];
        shifted_now = 1'b0;
        ch = 8'd0;
        if (esc_left != 2'd0) begin
          if (esc_left == 2'd2) esc_acc = esc_acc | {zc, 5'd0};
          else esc_acc = esc_acc | {5'd0, zc};
          esc_left = esc_left - 2'd1;
          if (esc_left == 2'd0) begin
            ch = escape_glyph(esc_acc);
            if (ch != 8'd0) push_res(KIND_CHAR, ch, 1'b0, 1'b0);
            cur_alpha = 2'd0;
            bank_pend = 2'd0;
            esc_acc   = 10'd0;
          end
        end else if (bank_pend != 2'd0) begin
          if (nested) begin
            push_res(KIND_ERROR, 8'd0, 1'b0, 1'b0);
            clear_carry();
            stop = 1'b1;
          end else begin
            push_res(KIND_ABBREV, 8'((int'(bank_pend) - 1) * 32 + int'(zc)), 1'b0, 1'b0);
            bank_pend = 2'd0;
            cur_alpha = 2'd0;
          end
        end else begin
          if (zc == 5'd0) begin
            ch = 8'h20;
          end else if (zc <= 5'd3) begin
            bank_pend = zc[1:0];
          end else if (zc <= 5'd5) begin
            shifted_now = 1'b1;
            cur_alpha = 2'(zc - 5'd3);
          end else if (zc == 5'd6 && cur_alpha == 2'd2) begin
            esc_left = 2'd2;
          end else begin
            ch = glyph(cur_alpha, zc);
          end
          if (ch != 8'd0) push_res(KIND_CHAR, ch, 1'b0, 1'b0);
          if (cur_alpha != 2'd0 && !shifted_now) cur_alpha = 2'd0;
        end
      end
    end
    push_res(KIND_DONE, 8'd0, w[15], 1'b1);
    if (w[15]) clear_carry();
  endtask

  always @(posedge clk) begin
    zres_t want;
    if (!rst_n) begin
      decoded_q.delete();
      clear_carry();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %02h eos %b last %b",
                                    out_kind, out_value, out_end_of_string, out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_kind !== want.kind || out_value !== want.value ||
              out_end_of_string !== want.eos || out_last !== want.last) begin
            report_mismatch($sformatf(
              "got kind %0d value %02h eos %b last %b, want kind %0d value %02h eos %b last %b",
              out_kind, out_value, out_end_of_string, out_last,
              want.kind, want.value, want.eos, want.last));
          end
        end
      end
      if (in_valid && in_ready) decode_word(in_text_word, in_in_abbreviation);
      pending = decoded_q.size();
    end
  end

endmodule

FILE: dv/tb_zstring_text_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zstring_text_decoder
// Drives text word requests into the z-string decoder and drains its result
// requests with random gaps and stalls. A directed run covers alphabets,
// shifts, escapes, abbreviations, nesting errors and end-of-string clearing;
// random strings and noise words follow. The checker grades every result.
// ----------------------------------------------------------------------------

module tb_zstring_text_decoder;

  localparam int QUIET_LIMIT = 2000;
  localparam int WORD_TARGET = 260;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_text_word;
  logic        in_in_abbreviation;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic        out_end_of_string;
  logic        out_last;

  int fail_count;
  int pending;
  int words_sent;
  int quiet_cycles;
  bit fast_mode;

  zstring_text_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_word       (in_text_word),
    .in_in_abbreviation (in_in_abbreviation),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_end_of_string  (out_end_of_string),
    .out_last           (out_last)
  );

  zstd_decode_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_word       (in_text_word),
    .in_in_abbreviation (in_in_abbreviation),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_value          (out_value),
    .out_end_of_string  (out_end_of_string),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_zstring_text_decoder NOT OK");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [15:0] zw(input logic e, input logic [4:0] a,
                                     input logic [4:0] b, input logic [4:0] c);
    return {e, a, b, c};
  endfunction

  task automatic send_word(input logic [15:0] w, input logic nested);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_text_word       <= w;
    in_in_abbreviation <= nested;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // one string of z-char tokens; terminated strings end with bit 15 set
  task automatic send_string(input bit terminate);
    logic [4:0] zq[$];
    logic [9:0] code;
    int         ntok;
    int         nest_mode;
    logic       nested;
    logic       eos;
    nest_mode = $urandom_range(0, 5);
    ntok = $urandom_range(1, 8);
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 9))
        0: zq.push_back(5'd0);
        4: begin
          if ($urandom_range(0, 1)) begin
            zq.push_back(5'd4);
            zq.push_back(5'($urandom_range(6, 31)));
          end else begin
            zq.push_back(5'd5);
            zq.push_back(5'($urandom_range(7, 31)));
          end
        end
        5: begin
          zq.push_back(5'($urandom_range(1, 3)));
          zq.push_back(5'($urandom_range(0, 31)));
        end
        6: begin
          case ($urandom_range(0, 5))
            0, 5:    code = 10'($urandom_range(32, 126));
            1:       code = 10'd13;
            2:       code = 10'd0;
            3:       code = 10'($urandom_range(1, 31));
            default: code = 10'($urandom_range(127, 1023));
          endcase
          zq.push_back(5'd5);
          zq.push_back(5'd6);
          zq.push_back(code[9:5]);
          zq.push_back(code[4:0]);
        end
        default: zq.push_back(5'($urandom_range(6, 31)));
      endcase
    end
    while (zq.size() % 3 != 0) zq.push_back(5'd5);
    for (int i = 0; i < zq.size(); i += 3) begin
      case (nest_mode)
        0:       nested = 1'b1;
        1:       nested = 1'($urandom_range(0, 1));
        default: nested = 1'b0;
      endcase
      eos = terminate && (i + 3 == zq.size());
      send_word(zw(eos, zq[i], zq[i+1], zq[i+2]), nested);
    end
  endtask

  initial begin
    int  pick;
    bit  paused;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_text_word       = 16'd0;
    in_in_abbreviation = 1'b0;
    fast_mode          = 1'b0;
    words_sent         = 0;
    paused             = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(zw(0, 0, 0, 0), 0);
    send_word(zw(1, 31, 31, 31), 0);
    send_word(zw(0, 6, 7, 8), 0);
    send_word(zw(0, 4, 6, 31), 0);
    send_word(zw(0, 5, 7, 5), 0);      // symbol shift carried into next word
    send_word(zw(0, 8, 5, 31), 0);
    send_word(zw(0, 5, 6, 2), 0);      // escape split across words
    send_word(zw(0, 1, 0, 0), 0);
    send_word(zw(0, 5, 6, 0), 0);      // escape 13 gives newline
    send_word(zw(0, 13, 4, 7), 0);
    send_word(zw(0, 5, 6, 0), 0);      // escape 0 gives nothing
    send_word(zw(0, 0, 5, 6), 0);
    send_word(zw(0, 3, 31, 0), 0);
    send_word(zw(0, 5, 6, 31), 0);     // escape 1023 and 126
    send_word(zw(0, 31, 5, 6), 0);
    send_word(zw(0, 3, 30, 5), 0);
    send_word(zw(0, 6, 1, 2), 0);
    send_word(zw(0, 1, 0, 3), 0);      // abbreviation indexes 0 and 95
    send_word(zw(0, 31, 2, 12), 0);
    send_word(zw(0, 2, 5, 6), 1);      // nested abbreviation
    send_word(zw(0, 6, 6, 1), 0);
    send_word(zw(0, 4, 6, 6), 1);
    send_word(zw(1, 6, 6, 4), 0);      // end of string drops pending shift
    send_word(zw(1, 5, 6, 1), 1);      // end of string drops open escape
    send_word(zw(0, 4, 5, 8), 1);
    send_word(zw(1, 4, 1, 6), 0);
    pause_until_drained();

    while (words_sent < WORD_TARGET) begin
      fast_mode = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_string(1'b1);
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 3)) send_word(16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        send_string(1'b0);
      end
      if (!paused && words_sent >= WORD_TARGET / 2) begin
        paused = 1'b1;
        pause_until_drained();
      end
    end
    fast_mode = 1'b0;

    pause_until_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_zstring_text_decoder OK");
    end else begin
      $display("tb_zstring_text_decoder NOT OK");
    end
    $finish;
  end

endmodule
